FILE: hw/rtl/sorted_unique_set_engine_core_macros.svh
// assertion macros shared by the sorted set engine rtl
`ifndef SORTED_UNIQUE_SET_ENGINE_CORE_MACROS_SVH
`define SORTED_UNIQUE_SET_ENGINE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define SUS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define SUS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SUS_ASSERT(lbl, clk, rst, prop, msg)

`define SUS_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: hw/rtl/sus_pkg.sv
// types and constants of the sorted set engine
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    RES_INSERTED = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_REMOVED  = 3'd2,
    RES_ABSENT   = 3'd3,
    RES_FULL     = 3'd4,
    RES_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] earliest_modified;
    logic [VAL_W-1:0] revision;
  } rsp_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sus_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sus_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sus_ctrl.sv
// sequencer: lower-bound search, tail shift and bookkeeping of the sorted set
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_unique_set_engine_core_macros.svh"

module sus_ctrl import sus_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output rsp_t                  res,
  output mem_req_t              mem,
  input  wire logic [VAL_W-1:0] mem_rd_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_HCHK,
    S_DECIDE,
    S_UP,
    S_DN,
    S_PUT,
    S_ZERO,
    S_RESP
  } state_t;

  state_t           state;
  logic [1:0]       op_kind;
  logic [VAL_W-1:0] op_value;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic             hit;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] mark;
  logic [VAL_W-1:0] rev;

  logic [CNT_W-1:0] mid_next;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] lo_p1;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] mark_next;

  assign mid_next  = lo + ((hi - lo) >> 1);
  assign cnt_m1    = cnt - CNT_W'(1);
  assign lo_p1     = lo + CNT_W'(1);
  assign idx_p1    = idx + CNT_W'(1);
  assign idx_m1    = idx - CNT_W'(1);
  assign mark_next = (lo < mark) ? lo : mark;
  assign req_stall = (state != S_IDLE);

  // memory requests follow the state; read data is registered and used in the following state
  always_comb begin
    mem = '0;
    case (state)
      S_SRCH: begin
        if (lo < hi) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = mid_next[IDX_W-1:0];
        end else if (lo < cnt) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = lo[IDX_W-1:0];
        end
      end
      S_DECIDE: begin
        if (op_kind == KIND_INSERT) begin
          if (!hit && cnt < CNT_W'(CAPACITY) && cnt > lo) begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = cnt_m1[IDX_W-1:0];
          end
        end else if (hit && lo_p1 < cnt) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = lo_p1[IDX_W-1:0];
        end
      end
      S_UP: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx_p1[IDX_W-1:0];
        mem.wr_data = mem_rd_data;
        if (idx != lo) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = idx_m1[IDX_W-1:0];
        end
      end
      S_DN: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx_m1[IDX_W-1:0];
        mem.wr_data = mem_rd_data;
        if (idx != cnt_m1) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = idx_p1[IDX_W-1:0];
        end
      end
      S_PUT: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = lo[IDX_W-1:0];
        mem.wr_data = op_value;
      end
      S_ZERO: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = cnt_m1[IDX_W-1:0];
        mem.wr_data = '0;
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      mark      <= CNT_W'(CAPACITY);
      rev       <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_kind  <= req.kind;
            op_value <= req.value;
            lo       <= '0;
            hi       <= cnt;
            case (req.kind)
              KIND_INSERT, KIND_REMOVE: begin
                state <= S_SRCH;
              end
              KIND_CLEAR: begin
                mark      <= CNT_W'(CAPACITY);
                res       <= '{status: RES_CLEARED, position: '0, entry_count: cnt,
                               earliest_modified: CNT_W'(CAPACITY), revision: rev};
                res_valid <= 1'b1;
                state     <= S_RESP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_SCMP;
          end else if (lo < cnt) begin
            state <= S_HCHK;
          end else begin
            hit   <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_SCMP: begin
          if (mem_rd_data < op_value) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_HCHK: begin
          hit   <= (mem_rd_data == op_value);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (op_kind == KIND_INSERT) begin
            if (hit || cnt >= CNT_W'(CAPACITY)) begin
              res       <= '{status: hit ? RES_PRESENT : RES_FULL, position: lo,
                             entry_count: cnt, earliest_modified: mark, revision: rev};
              res_valid <= 1'b1;
              state     <= S_RESP;
            end else if (cnt > lo) begin
              idx   <= cnt_m1;
              state <= S_UP;
            end else begin
              state <= S_PUT;
            end
          end else begin
            if (!hit) begin
              res       <= '{status: RES_ABSENT, position: lo, entry_count: cnt,
                             earliest_modified: mark, revision: rev};
              res_valid <= 1'b1;
              state     <= S_RESP;
            end else if (lo_p1 < cnt) begin
              idx   <= lo_p1;
              state <= S_DN;
            end else begin
              state <= S_ZERO;
            end
          end
        end
        S_UP: begin
          if (idx == lo) begin
            state <= S_PUT;
          end else begin
            idx <= idx_m1;
          end
        end
        S_DN: begin
          if (idx == cnt_m1) begin
            state <= S_ZERO;
          end else begin
            idx <= idx_p1;
          end
        end
        S_PUT: begin
          cnt       <= cnt + CNT_W'(1);
          rev       <= rev + VAL_W'(1);
          mark      <= mark_next;
          res       <= '{status: RES_INSERTED, position: lo, entry_count: cnt + CNT_W'(1),
                         earliest_modified: mark_next, revision: rev + VAL_W'(1)};
          res_valid <= 1'b1;
          state     <= S_RESP;
        end
        S_ZERO: begin
          cnt       <= cnt_m1;
          rev       <= rev + VAL_W'(1);
          mark      <= mark_next;
          res       <= '{status: RES_REMOVED, position: lo, entry_count: cnt_m1,
                         earliest_modified: mark_next, revision: rev + VAL_W'(1)};
          res_valid <= 1'b1;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SUS_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(CAPACITY), "entry count above capacity")
  `SUS_ASSERT(a_mark_bound, clk, rst, mark <= CNT_W'(CAPACITY), "modified mark out of range")
  `SUS_ASSERT(a_rev_with_cnt, clk, rst, (!$past(rst) && rev != $past(rev)) |-> (cnt != $past(cnt)), "revision moved without a change of count")
  `SUS_ASSERT(a_accept_search, clk, rst, (req_valid && !req_stall && (req.kind == KIND_INSERT || req.kind == KIND_REMOVE)) |=> (state == S_SRCH), "insert or remove did not start a search")
  `SUS_ASSERT(a_res_hold, clk, rst, (res_valid && !res_ready) |=> (res_valid && $stable(res)), "pending result dropped or changed")
  `SUS_ASSERT_NEVER(a_no_write_search, clk, rst, mem.wr_en && (state == S_SRCH || state == S_SCMP || state == S_HCHK), "store written during search")

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_unique_set_engine_core.sv
// top level of the sorted set engine: sequencer, value store and result register
`timescale 1ns / 1ps
`default_nettype none

// sorted unique set engine: keeps up to CAPACITY distinct 32-bit values in
// ascending order in a single-port-write, single-port-read ram. each request
// transaction (insert, remove or clear of the earliest-modified mark) gives
// exactly one response transaction; kind 3 is taken and dropped silently.
// the engine works on one request at a time and stalls the request side
// meanwhile. a request is accepted, then a binary search runs (each probe
// is a ram read plus a compare), followed by the last probe, the hit check
// and the decision. a successful insert or remove then moves one entry per
// cycle in the tail shift, then does the final write with its bookkeeping
// and the handoff to the output register. the tail shift reads one entry
// and writes its neighbour in the same cycle. results sit in an output
// register, so the next request is taken while an earlier response is
// still stalled. no clearing pass is needed after reset: only entries
// below the count are ever read.
module sorted_unique_set_engine_core import sus_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // sequencer to output register
  logic     res_valid;
  logic     res_ready;
  rsp_t     res;

  // store access
  mem_req_t         mem;
  logic [VAL_W-1:0] mem_rd_data;

  sus_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem         (mem),
    .mem_rd_data (mem_rd_data)
  );

  sus_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload loads only on a handoff, so a stalled response holds
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire
